### design/irpd_pkg.sv
// Shared types and constants of the IR pulse-distance decoder.
package irpd_pkg;

    localparam int TICK_W   = 8;
    localparam int STATUS_W = 2;
    localparam int CODE_W   = 32;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_LEADER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_BIT    = 2'd2;

    localparam logic [2:0] REG_LEADER_MIN = 3'd0;
    localparam logic [2:0] REG_LEADER_MAX = 3'd1;
    localparam logic [2:0] REG_ZERO_MIN   = 3'd2;
    localparam logic [2:0] REG_ZERO_MAX   = 3'd3;
    localparam logic [2:0] REG_ONE_MIN    = 3'd4;
    localparam logic [2:0] REG_ONE_MAX    = 3'd5;

    localparam logic [TICK_W-1:0] RST_LEADER_MIN = 8'd156;
    localparam logic [TICK_W-1:0] RST_LEADER_MAX = 8'd190;
    localparam logic [TICK_W-1:0] RST_ZERO_MIN   = 8'd12;
    localparam logic [TICK_W-1:0] RST_ZERO_MAX   = 8'd30;
    localparam logic [TICK_W-1:0] RST_ONE_MIN    = 8'd57;
    localparam logic [TICK_W-1:0] RST_ONE_MAX    = 8'd71;

    typedef struct packed {
        logic [TICK_W-1:0] leader_min;
        logic [TICK_W-1:0] leader_max;
        logic [TICK_W-1:0] zero_min;
        logic [TICK_W-1:0] zero_max;
        logic [TICK_W-1:0] one_min;
        logic [TICK_W-1:0] one_max;
    } t_cfg;

endpackage

### design/irpd_in_if.sv
// Request channel carrying one measured space length.
interface irpd_in_if;
    logic                         valid;
    logic                         ready;
    logic [irpd_pkg::TICK_W-1:0]  space_ticks;

    modport source (output valid, output space_ticks, input ready);
    modport sink   (input valid, input space_ticks, output ready);
endinterface

### design/irpd_out_if.sv
// Result channel carrying decode status and received code.
interface irpd_out_if;
    logic                          valid;
    logic                          ready;
    logic [irpd_pkg::STATUS_W-1:0] status;
    logic [irpd_pkg::CODE_W-1:0]   code;

    modport source (output valid, output status, output code, input ready);
    modport sink   (input valid, input status, input code, output ready);
endinterface

### design/ir_pulse_distance_decoder.sv
// IR pulse-distance decoder: leader check, bit windows, code assembly.
// An accepted space is held in the input register and decoded from there;
// its result, if any, is written to the result register and presented from it.
// Throughput: one space per cycle while the result register is free or being drained, set by the single decode stage.
// Reset clears the frame state and both stage valids, and returns the window registers to their defaults.
module ir_pulse_distance_decoder #(
    parameter int CODE_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [irpd_pkg::ADDR_W-1:0] paddr,
    input  logic [irpd_pkg::DATA_W-1:0] pwdata,
    output logic [irpd_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    irpd_in_if.sink                     i_in,
    irpd_out_if.source                  o_out
);
    import irpd_pkg::*;

    localparam int CNT_W = $clog2(CODE_BITS);
    localparam int EXT_W = (CODE_BITS > CODE_W) ? CODE_BITS : CODE_W;

    t_cfg cfg;

    irpd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic                  r_in_valid;
    logic [TICK_W-1:0]     r_ticks;
    logic                  r_in_frame,  n_in_frame;
    logic [CNT_W-1:0]      r_bits,      n_bits;
    logic [CODE_BITS-1:0]  r_word,      n_word;
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_status,    n_status;
    logic [CODE_W-1:0]     r_code,      n_code;
    logic                  n_emit;

    logic                  advance;
    logic                  hit_lead, hit_one, hit_zero;
    logic [CODE_BITS-1:0]  shifted;
    logic [EXT_W-1:0]      code_ext;

    // The decode stage moves when the result register is free or being drained.
    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;

    assign o_out.valid  = r_out_valid;
    assign o_out.status = r_status;
    assign o_out.code   = r_code;

    assign hit_lead = (r_ticks >= cfg.leader_min) && (r_ticks <= cfg.leader_max);
    assign hit_one  = (r_ticks >= cfg.one_min)    && (r_ticks <= cfg.one_max);
    assign hit_zero = (r_ticks >= cfg.zero_min)   && (r_ticks <= cfg.zero_max);
    assign shifted  = {r_word[CODE_BITS-2:0], hit_one};
    assign code_ext = EXT_W'(shifted);

    always_comb begin
        n_in_frame = r_in_frame;
        n_bits     = r_bits;
        n_word     = r_word;
        n_emit     = 1'b0;
        n_status   = ST_DONE;
        n_code     = '0;
        if (!r_in_frame) begin
            if (hit_lead) begin
                n_in_frame = 1'b1;
                n_bits     = '0;
                n_word     = '0;
            end else begin
                n_emit   = 1'b1;
                n_status = ST_BAD_LEADER;
            end
        end else if (hit_one || hit_zero) begin
            if (r_bits == CNT_W'(CODE_BITS - 1)) begin
                n_emit     = 1'b1;
                n_status   = ST_DONE;
                n_code     = code_ext[CODE_W-1:0];
                n_in_frame = 1'b0;
                n_bits     = '0;
                n_word     = '0;
            end else begin
                n_bits = r_bits + 1'b1;
                n_word = shifted;
            end
        end else begin
            n_emit     = 1'b1;
            n_status   = ST_BAD_BIT;
            n_in_frame = 1'b0;
            n_bits     = '0;
            n_word     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_in_frame  <= 1'b0;
            r_bits      <= '0;
            r_word      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_in_frame <= n_in_frame;
                r_bits     <= n_bits;
                r_word     <= n_word;
            end
            if (advance && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_ticks <= i_in.space_ticks;
        end
        if (advance && n_emit) begin
            r_status <= n_status;
            r_code   <= n_code;
        end
    end
endmodule

### design/irpd_regs.sv
// APB-style register file holding the decode window bounds.
module irpd_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [irpd_pkg::ADDR_W-1:0] paddr,
    input  logic [irpd_pkg::DATA_W-1:0] pwdata,
    output logic [irpd_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output irpd_pkg::t_cfg              o_cfg
);
    import irpd_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] idx;
    logic       wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.leader_min <= RST_LEADER_MIN;
            r_cfg.leader_max <= RST_LEADER_MAX;
            r_cfg.zero_min   <= RST_ZERO_MIN;
            r_cfg.zero_max   <= RST_ZERO_MAX;
            r_cfg.one_min    <= RST_ONE_MIN;
            r_cfg.one_max    <= RST_ONE_MAX;
        end else if (wr_en) begin
            case (idx)
                REG_LEADER_MIN: r_cfg.leader_min <= pwdata[TICK_W-1:0];
                REG_LEADER_MAX: r_cfg.leader_max <= pwdata[TICK_W-1:0];
                REG_ZERO_MIN:   r_cfg.zero_min   <= pwdata[TICK_W-1:0];
                REG_ZERO_MAX:   r_cfg.zero_max   <= pwdata[TICK_W-1:0];
                REG_ONE_MIN:    r_cfg.one_min    <= pwdata[TICK_W-1:0];
                REG_ONE_MAX:    r_cfg.one_max    <= pwdata[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_LEADER_MIN: prdata = DATA_W'(r_cfg.leader_min);
            REG_LEADER_MAX: prdata = DATA_W'(r_cfg.leader_max);
            REG_ZERO_MIN:   prdata = DATA_W'(r_cfg.zero_min);
            REG_ZERO_MAX:   prdata = DATA_W'(r_cfg.zero_max);
            REG_ONE_MIN:    prdata = DATA_W'(r_cfg.one_min);
            REG_ONE_MAX:    prdata = DATA_W'(r_cfg.one_max);
            default:        prdata = '0;
        endcase
    end
endmodule

### tb/sv/irpd_frame_check.sv
// Scoreboard that predicts decoder results from observed spaces and register writes.
module irpd_frame_check #(
    parameter int FRAME_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [irpd_pkg::ADDR_W-1:0] paddr,
    input  logic [irpd_pkg::DATA_W-1:0] pwdata,
    irpd_in_if                          i_in,
    irpd_out_if                         i_res,
    output int                          o_errors,
    output int                          o_pending
);
    import irpd_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CODE_W-1:0]   code;
    } t_result;

    t_result     expected_q[$];
    t_cfg        windows;
    logic        in_frame;
    int unsigned bits_taken;
    logic [63:0] shift_word;
    int          err_count = 0;

    function automatic logic in_range(input logic [TICK_W-1:0] v,
                                      input logic [TICK_W-1:0] lo,
                                      input logic [TICK_W-1:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    // Decodes one accepted space and queues the result it causes, if any.
    task automatic decode_space(input logic [TICK_W-1:0] t);
        t_result r;
        logic    bit_ok;
        r.code = '0;
        r.status = ST_DONE;
        if (!in_frame) begin
            if (in_range(t, windows.leader_min, windows.leader_max)) begin
                in_frame   = 1'b1;
                bits_taken = 0;
                shift_word = '0;
            end else begin
                r.status = ST_BAD_LEADER;
                expected_q.push_back(r);
            end
        end else begin
            bit_ok = 1'b1;
            // The one window wins where the two windows overlap.
            if (in_range(t, windows.one_min, windows.one_max)) begin
                shift_word = {shift_word[62:0], 1'b1};
            end else if (in_range(t, windows.zero_min, windows.zero_max)) begin
                shift_word = {shift_word[62:0], 1'b0};
            end else begin
                bit_ok = 1'b0;
            end
            if (!bit_ok) begin
                r.status = ST_BAD_BIT;
                expected_q.push_back(r);
                in_frame   = 1'b0;
                bits_taken = 0;
                shift_word = '0;
            end else begin
                bits_taken++;
                if (bits_taken >= FRAME_BITS) begin
                    r.code = shift_word[CODE_W-1:0];
                    expected_q.push_back(r);
                    in_frame   = 1'b0;
                    bits_taken = 0;
                    shift_word = '0;
                end
            end
        end
    endtask

    task automatic note_mismatch(input string what, input t_result want,
                                 input t_result got);
        err_count++;
        if (err_count <= 10) begin
            $display("mismatch, %s: expected status %0d code %h, got status %0d code %h",
                     what, want.status, want.code, got.status, got.code);
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            windows    = '{leader_min: RST_LEADER_MIN, leader_max: RST_LEADER_MAX,
                           zero_min: RST_ZERO_MIN, zero_max: RST_ZERO_MAX,
                           one_min: RST_ONE_MIN, one_max: RST_ONE_MAX};
            in_frame   = 1'b0;
            bits_taken = 0;
            shift_word = '0;
            expected_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_LEADER_MIN: windows.leader_min = pwdata[TICK_W-1:0];
                    REG_LEADER_MAX: windows.leader_max = pwdata[TICK_W-1:0];
                    REG_ZERO_MIN:   windows.zero_min   = pwdata[TICK_W-1:0];
                    REG_ZERO_MAX:   windows.zero_max   = pwdata[TICK_W-1:0];
                    REG_ONE_MIN:    windows.one_min    = pwdata[TICK_W-1:0];
                    REG_ONE_MAX:    windows.one_max    = pwdata[TICK_W-1:0];
                    default: ;
                endcase
            end
            // Results always trail their spaces, so they are checked first.
            if (i_res.valid && i_res.ready) begin
                got.status = i_res.status;
                got.code   = i_res.code;
                if (expected_q.size() == 0) begin
                    note_mismatch("result with nothing expected", '0, got);
                end else begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status || got.code !== want.code) begin
                        note_mismatch("wrong result", want, got);
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                decode_space(i_in.space_ticks);
            end
        end
        o_pending <= expected_q.size();
        o_errors  <= err_count;
    end

endmodule

### tb/sv/ir_pulse_distance_decoder_tb.sv
// Testbench top: clock, reset, register writes and space stimulus for the IR decoder.
module ir_pulse_distance_decoder_tb;
    import irpd_pkg::*;

    localparam int FRAME_BITS = 32;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int   fail_count;
    int   pending_count;
    int   snd_idle_pct = 21;
    int   rcv_idle_pct = 66;
    int   items_sent   = 0;
    int   phase_end;
    int   roll;
    t_cfg windows;

    irpd_in_if  in_ch ();
    irpd_out_if res_ch ();

    ir_pulse_distance_decoder #(
        .CODE_BITS (FRAME_BITS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch),
        .o_out   (res_ch)
    );

    irpd_frame_check #(
        .FRAME_BITS (FRAME_BITS)
    ) u_frame_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .i_in      (in_ch),
        .i_res     (res_ch),
        .o_errors  (fail_count),
        .o_pending (pending_count)
    );

    always begin
        #6;
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    initial begin
        #(12 * 200_000);
        $display("FAIL ir_pulse_distance_decoder");
        $finish;
    end

    function automatic t_cfg make_windows(input logic [TICK_W-1:0] lmin, lmax,
                                          input logic [TICK_W-1:0] zmin, zmax,
                                          input logic [TICK_W-1:0] omin, omax);
        t_cfg c;
        c.leader_min = lmin;
        c.leader_max = lmax;
        c.zero_min   = zmin;
        c.zero_max   = zmax;
        c.one_min    = omin;
        c.one_max    = omax;
        return c;
    endfunction

    // Mostly ordered bounds; now and then a pair is left reversed, which empties it.
    function automatic t_cfg random_windows();
        logic [TICK_W-1:0] b [6];
        logic [TICK_W-1:0] tmp;
        foreach (b[k]) b[k] = TICK_W'($urandom);
        for (int k = 0; k < 6; k += 2) begin
            if (b[k] > b[k+1] && $urandom_range(3) != 0) begin
                tmp    = b[k];
                b[k]   = b[k+1];
                b[k+1] = tmp;
            end
        end
        return make_windows(b[0], b[1], b[2], b[3], b[4], b[5]);
    endfunction

    function automatic logic [TICK_W-1:0] pick_in(input logic [TICK_W-1:0] lo,
                                                  input logic [TICK_W-1:0] hi);
        int unsigned r;
        r = $urandom_range(7);
        if (lo > hi) return TICK_W'($urandom);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return TICK_W'($urandom_range(hi, lo));
    endfunction

    // Values just outside a window, or anything at all.
    function automatic logic [TICK_W-1:0] pick_stray(input logic [TICK_W-1:0] lo,
                                                     input logic [TICK_W-1:0] hi);
        int unsigned r;
        r = $urandom_range(3);
        if (r == 0) return lo - 8'd1;
        if (r == 1) return hi + 8'd1;
        return TICK_W'($urandom);
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [TICK_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(DATA_W-TICK_W){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_windows(input t_cfg c);
        windows = c;
        write_reg(REG_LEADER_MIN, c.leader_min);
        write_reg(REG_LEADER_MAX, c.leader_max);
        write_reg(REG_ZERO_MIN,   c.zero_min);
        write_reg(REG_ZERO_MAX,   c.zero_max);
        write_reg(REG_ONE_MIN,    c.one_min);
        write_reg(REG_ONE_MAX,    c.one_max);
    endtask

    task automatic send_space(input logic [TICK_W-1:0] t);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.space_ticks <= t;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // Waits for every expected result, then lets trailing spaces finish decoding.
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (6) @(posedge i_clk);
    endtask

    // A leader and a full frame of bits, sometimes broken off by a stray space.
    task automatic send_frame();
        int cut;
        cut = ($urandom_range(7) == 0) ? $urandom_range(FRAME_BITS, 1) : 0;
        send_space(pick_in(windows.leader_min, windows.leader_max));
        for (int k = 1; k <= FRAME_BITS; k++) begin
            if (k == cut) begin
                if ($urandom_range(1)) send_space(pick_stray(windows.one_min, windows.one_max));
                else send_space(pick_stray(windows.zero_min, windows.zero_max));
                return;
            end
            if ($urandom_range(1)) send_space(pick_in(windows.one_min, windows.one_max));
            else send_space(pick_in(windows.zero_min, windows.zero_max));
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.space_ticks <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: leader edges, bit window edges and stray bits at reset windows.
        write_windows(make_windows(RST_LEADER_MIN, RST_LEADER_MAX, RST_ZERO_MIN,
                                   RST_ZERO_MAX, RST_ONE_MIN, RST_ONE_MAX));
        send_space(8'd0);
        send_space(8'd255);
        send_space(8'd155);
        send_space(8'd191);
        send_space(8'd156);
        send_space(8'd71);
        send_space(8'd57);
        send_space(8'd30);
        send_space(8'd12);
        send_space(8'd11);
        send_space(8'd190);
        send_space(8'd72);
        send_space(8'd156);
        send_space(8'd56);
        send_space(8'd190);
        send_space(8'd31);
        send_space(8'd170);
        send_space(8'd0);
        send_space(8'd170);
        send_space(8'd255);
        settle();

        // Overlapping windows: a space in both decodes as a one.
        write_windows(make_windows(8'd0, 8'd255, 8'd10, 8'd70, 8'd50, 8'd60));
        send_space(8'd0);
        send_space(8'd55);
        send_space(8'd70);
        send_space(8'd50);
        send_space(8'd60);
        send_space(8'd9);

        for (int p = 0; p < 6; p++) begin
            settle();
            case (p)
                0: windows = make_windows(RST_LEADER_MIN, RST_LEADER_MAX, RST_ZERO_MIN,
                                          RST_ZERO_MAX, RST_ONE_MIN, RST_ONE_MAX);
                1: windows = random_windows();
                2: windows = make_windows(8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255);
                3: windows = make_windows(8'd0, 8'd0, 8'd200, 8'd100, 8'd20, 8'd40);
                4: windows = make_windows(8'd255, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
                default: windows = random_windows();
            endcase
            write_windows(windows);
            snd_idle_pct = (p < 2) ? 21 : (p < 4) ? 66 : 0;
            rcv_idle_pct = (p < 2) ? 66 : (p < 4) ? 21 : 0;
            phase_end = items_sent + 170;
            while (items_sent < phase_end) begin
                roll = $urandom_range(9);
                if (roll < 7) begin
                    send_frame();
                end else if (roll == 7) begin
                    send_space(pick_stray(windows.leader_min, windows.leader_max));
                end else begin
                    repeat ($urandom_range(5, 1)) send_space(TICK_W'($urandom));
                end
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("PASS ir_pulse_distance_decoder");
        end else begin
            $display("FAIL ir_pulse_distance_decoder");
        end
        $finish;
    end

endmodule
